/* rtl/modular_exponentiation_key_agreement_unit_defines.svh */
// Assertion macros shared by the RTL files. They compile to nothing in synthesis.
`ifndef MODULAR_EXPONENTIATION_KEY_AGREEMENT_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_KEY_AGREEMENT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MEXP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MEXP_ASSERT(lbl, prop, msg)
`define MEXP_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/mexp_pkg.sv */
package mexp_pkg;

  localparam int unsigned WORD_W       = 64;
  localparam int unsigned EXP_W        = 32;
  localparam int unsigned EXP_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [WORD_W-1:0] MODULUS_RST   = 64'd23;
  localparam logic [WORD_W-1:0] GENERATOR_RST = 64'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_SQR,
    ST_MUL,
    ST_FIN
  } state_e;

endpackage

/* rtl/mexp_mulmod.sv */
`include "modular_exponentiation_key_agreement_unit_defines.svh"

module mexp_mulmod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mexp_pkg::WORD_W-1:0] x_i,
  input  logic [mexp_pkg::WORD_W-1:0] y_i,
  input  logic [mexp_pkg::WORD_W-1:0] mod_i,
  output logic                        done_o,
  output logic [mexp_pkg::WORD_W-1:0] res_o
);

  localparam int unsigned W     = mexp_pkg::WORD_W;
  localparam int unsigned CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     x_q, x_d;
  logic [W-1:0]     y_q, y_d;

  logic [W+1:0] sum;
  logic [W+1:0] m1;
  logic [W+1:0] m2;
  logic [W+1:0] diff1;
  logic [W+1:0] diff2;
  logic [W-1:0] step;

  // One bit of y per cycle, MSB first: acc = (2*acc + bit*x) mod m.
  // With acc and x below m the sum stays below 3m, so at most 2m comes off.
  assign sum   = {1'b0, acc_q, 1'b0} + {2'b00, x_q & {W{y_q[W-1]}}};
  assign m1    = {2'b00, mod_i};
  assign m2    = {1'b0, mod_i, 1'b0};
  assign diff1 = sum - m1;
  assign diff2 = sum - m2;

  always_comb begin
    if (mod_i == '0) begin
      // A zero modulus stands for 2^W, which is plain wrap-around.
      step = sum[W-1:0];
    end else if (sum >= m2) begin
      step = diff2[W-1:0];
    end else if (sum >= m1) begin
      step = diff1[W-1:0];
    end else begin
      step = sum[W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
    end else if (busy_q) begin
      acc_d = step;
      y_d   = {y_q[W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

  `MEXP_NEVER(a_start_while_busy, start_i && busy_q, "multiply started while busy")
  `MEXP_ASSERT(a_acc_reduced, busy_q && mod_i != '0 |-> acc_q < mod_i, "accumulator not reduced")
  `MEXP_ASSERT(a_done_after_busy, done_q |-> $past(busy_q) && !busy_q, "done without a run")

endmodule

/* rtl/modular_exponentiation_key_agreement_unit.sv */
// Channel   Direction  Handshake                   Payload
// input     in         in_valid_i / in_stall_o     kind_i, exponent_i, partner_value_i
// output    out        out_valid_o / out_stall_i   power_mod_o
// config    in         cfg_we_i                    cfg_idx_i, cfg_data_i
//
// Each item runs one base reduction, then a squaring for each of the low EXP_BITS bits of
// the exponent and a multiplication for each of those bits that is set; every product goes
// through the bit-serial modular multiplier.
// The unit works on one item at a time; the result waits in an output register, so a new
// item is taken while it is stalled, and that item only waits at its very end.
// Reset is asynchronous and active low; it sets modulus to 23 and generator to 5.
`include "modular_exponentiation_key_agreement_unit_defines.svh"

module modular_exponentiation_key_agreement_unit #(
  parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [mexp_pkg::EXP_W-1:0]     exponent_i,
  input  logic [mexp_pkg::WORD_W-1:0]    partner_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mexp_pkg::WORD_W-1:0]    power_mod_o,
  input  logic                           cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mexp_pkg::WORD_W-1:0]    cfg_data_i
);

  localparam int unsigned W     = mexp_pkg::WORD_W;
  localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

  mexp_pkg::state_e state_q, state_d;

  logic [W-1:0]        modulus_q;
  logic [W-1:0]        generator_q;
  logic [W-1:0]        base_q, base_d;
  logic [W-1:0]        r_q, r_d;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                run_q, run_d;
  logic                out_valid_q, out_valid_d;
  logic [W-1:0]        out_q, out_d;

  logic         mm_start;
  logic [W-1:0] mm_x;
  logic [W-1:0] mm_y;
  logic         mm_done;
  logic [W-1:0] mm_res;
  logic [W-1:0] one_mod;
  logic [63:0]  exp_ext;
  logic         out_free;

  assign one_mod  = (modulus_q == W'(1)) ? '0 : W'(1);
  assign exp_ext  = {32'd0, exponent_i};
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= mexp_pkg::MODULUS_RST;
      generator_q <= mexp_pkg::GENERATOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mexp_pkg::CFG_MODULUS:   modulus_q   <= cfg_data_i;
        mexp_pkg::CFG_GENERATOR: generator_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Base reduction runs through the multiplier as (1 mod m) times base.
  always_comb begin
    unique case (state_q)
      mexp_pkg::ST_RED: begin
        mm_x = one_mod;
        mm_y = base_q;
      end
      mexp_pkg::ST_MUL: begin
        mm_x = base_q;
        mm_y = r_q;
      end
      default: begin
        mm_x = r_q;
        mm_y = r_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    r_d         = r_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mm_start    = 1'b0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          base_d  = kind_i ? partner_value_i : generator_q;
          exp_d   = exp_ext[EXP_BITS-1:0];
          cnt_d   = CNT_W'(EXP_BITS);
          run_d   = 1'b0;
          state_d = mexp_pkg::ST_RED;
        end
      end
      mexp_pkg::ST_RED, mexp_pkg::ST_SQR, mexp_pkg::ST_MUL: begin
        if (!run_q) begin
          mm_start = 1'b1;
          run_d    = 1'b1;
        end else if (mm_done) begin
          run_d = 1'b0;
          if (state_q == mexp_pkg::ST_RED) begin
            base_d  = mm_res;
            r_d     = one_mod;
            state_d = mexp_pkg::ST_SQR;
          end else begin
            r_d = mm_res;
            if (state_q == mexp_pkg::ST_SQR && exp_q[EXP_BITS-1]) begin
              state_d = mexp_pkg::ST_MUL;
            end else begin
              exp_d   = {exp_q[EXP_BITS-2:0], 1'b0};
              cnt_d   = cnt_q - 1'b1;
              state_d = (cnt_q == CNT_W'(1)) ? mexp_pkg::ST_FIN : mexp_pkg::ST_SQR;
            end
          end
        end
      end
      mexp_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = r_q;
          state_d     = mexp_pkg::ST_IDLE;
        end
      end
      default: state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      run_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    r_q    <= r_d;
    exp_q  <= exp_d;
    out_q  <= out_d;
  end

  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .mod_i   (modulus_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_q;

  `MEXP_ASSERT(a_accept_starts, in_valid_i && !in_stall_o |=> state_q == mexp_pkg::ST_RED, "accepted item did not start")
  `MEXP_ASSERT(a_r_reduced, mm_start && state_q == mexp_pkg::ST_SQR && modulus_q != '0 |-> r_q < modulus_q, "running power not reduced")
  `MEXP_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == mexp_pkg::ST_FIN), "result shown outside finish")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned HOLD_CYCLES  = 15000;
  localparam int unsigned DRAIN_CYCLES = 4400;
  localparam int unsigned CYCLE_LIMIT  = 8000000;

  localparam logic KIND_PUBLIC = 1'b0;
  localparam logic KIND_SHARED = 1'b1;

  // Tracks the two registers and predicts power_mod for every accepted item.
  class power_mod_tracker;
    logic [mexp_pkg::WORD_W-1:0] modulus;
    logic [mexp_pkg::WORD_W-1:0] generator;
    logic [mexp_pkg::WORD_W-1:0] pending_powers[$];
    int mismatch_count;

    function new();
      modulus        = 64'd23;
      generator      = 64'd5;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [mexp_pkg::CFG_IDX_W-1:0] idx,
                               logic [mexp_pkg::WORD_W-1:0] value);
      if (idx == mexp_pkg::CFG_MODULUS) begin
        modulus = value;
      end else if (idx == mexp_pkg::CFG_GENERATOR) begin
        generator = value;
      end
    endfunction

    // Left-to-right square-and-multiply over all exponent bits. Products are
    // formed at 128 bits, so they never overflow before the reduction.
    function logic [mexp_pkg::WORD_W-1:0] raise_mod(logic [mexp_pkg::WORD_W-1:0] base,
                                                    logic [mexp_pkg::EXP_W-1:0] e);
      logic [127:0] m;
      logic [127:0] r;
      logic [127:0] b;
      int i;
      // A zero modulus stands for 2^64, which gives plain wrap-around.
      m = (modulus == '0) ? (128'd1 << 64) : {64'd0, modulus};
      r = 128'd1 % m;
      b = {64'd0, base} % m;
      for (i = mexp_pkg::EXP_W - 1; i >= 0; i--) begin
        r = (r * r) % m;
        if (e[i]) begin
          r = (r * b) % m;
        end
      end
      return r[63:0];
    endfunction

    function void note_item(bit shared, logic [mexp_pkg::EXP_W-1:0] e,
                            logic [mexp_pkg::WORD_W-1:0] partner);
      pending_powers.push_back(raise_mod(shared ? partner : generator, e));
    endfunction

    function void report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatch_count++;
    endfunction

    function void check_power(logic [mexp_pkg::WORD_W-1:0] got);
      logic [mexp_pkg::WORD_W-1:0] want;
      if (pending_powers.size() == 0) begin
        report_mismatch($sformatf("power_mod %h arrived with no item pending", got));
      end else begin
        want = pending_powers.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("power_mod got %h, expected %h", got, want));
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           kind;
  logic [mexp_pkg::EXP_W-1:0]     exponent;
  logic [mexp_pkg::WORD_W-1:0]    partner_value;
  logic                           out_valid;
  logic                           out_stall;
  logic [mexp_pkg::WORD_W-1:0]    power_mod;
  logic                           cfg_we;
  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [mexp_pkg::WORD_W-1:0]    cfg_data;

  bit hold_request = 1'b0;
  bit quiet        = 1'b0;

  power_mod_tracker tracker;

  always #5 clk = ~clk;

  modular_exponentiation_key_agreement_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .exponent_i      (exponent),
    .partner_value_i (partner_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .power_mod_o     (power_mod),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 60);
    return $urandom_range(100, 3000);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.note_item(kind == KIND_SHARED, exponent, partner_value);
      end
      if (out_valid && !out_stall) begin
        tracker.check_power(power_mod);
      end
    end
  end

  // Output side: random stall runs, one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 1) == 1);
        repeat (1 + idle_cycles()) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic k, input logic [mexp_pkg::EXP_W-1:0] e,
                           input logic [mexp_pkg::WORD_W-1:0] p);
    int gap;
    in_valid      <= 1'b1;
    kind          <= k;
    exponent      <= e;
    partner_value <= p;
    do @(posedge clk); while (in_stall);
    gap = quiet ? 0 : idle_cycles();
    // With no gap, valid simply stays high for the next item.
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [mexp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mexp_pkg::WORD_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    tracker.set_register(idx, value);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_powers.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random_phase(input int count);
    logic [mexp_pkg::EXP_W-1:0]  e;
    logic [mexp_pkg::WORD_W-1:0] p;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: e = $urandom_range(0, 15);
        1: e = '1;
        2: e = 32'd1 << $urandom_range(0, 31);
        default: e = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0: p = '0;
        1: p = '1;
        2: p = 64'($urandom_range(0, 1000));
        3: p = tracker.modulus - 64'd1 + 64'($urandom_range(0, 1));
        default: p = {$urandom, $urandom};
      endcase
      send_item($urandom_range(0, 1) == 1, e, p);
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    tracker = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    kind          <= KIND_PUBLIC;
    exponent      <= '0;
    partner_value <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= mexp_pkg::CFG_MODULUS;
    cfg_data      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers as left by reset.
    send_item(KIND_PUBLIC, '0, '0);
    send_item(KIND_PUBLIC, 32'd1, '1);
    send_item(KIND_PUBLIC, '1, 64'h0123_4567_89ab_cdef);
    send_item(KIND_SHARED, '0, '0);
    send_item(KIND_SHARED, 32'd5, '0);
    send_item(KIND_SHARED, '1, '1);
    send_item(KIND_SHARED, 32'd3, 64'd23);
    send_item(KIND_SHARED, 32'h8000_0001, 64'd22);
    wait_idle();

    // Modulus one forces every result to zero.
    write_register(mexp_pkg::CFG_MODULUS, 64'd1);
    send_item(KIND_PUBLIC, '0, '0);
    send_item(KIND_SHARED, '1, '1);
    wait_idle();

    write_register(mexp_pkg::CFG_MODULUS, '1);
    write_register(mexp_pkg::CFG_GENERATOR, '1);
    send_item(KIND_PUBLIC, 32'd2, '0);
    send_item(KIND_SHARED, '1, 64'hffff_ffff_ffff_fffe);
    send_item(KIND_SHARED, 32'd1, '1);
    wait_idle();

    write_register(mexp_pkg::CFG_MODULUS, 64'd97);
    write_register(mexp_pkg::CFG_GENERATOR, '0);
    send_item(KIND_PUBLIC, '0, '1);
    send_item(KIND_PUBLIC, 32'd7, '0);
    send_item(KIND_SHARED, '1, 64'd96);
    wait_idle();

    write_register(mexp_pkg::CFG_MODULUS, 64'd2);
    write_register(mexp_pkg::CFG_GENERATOR, 64'd3);
    send_item(KIND_PUBLIC, 32'd1, '0);
    send_item(KIND_SHARED, '1, 64'd1);
    wait_idle();

    // The output side holds off long enough for the unit to back up its input.
    write_register(mexp_pkg::CFG_MODULUS, {$urandom, $urandom} | 64'd1);
    write_register(mexp_pkg::CFG_GENERATOR, {$urandom, $urandom});
    hold_request = 1'b1;
    run_random_phase(30);
    wait_idle();

    write_register(mexp_pkg::CFG_MODULUS, 64'($urandom_range(2, 1000)));
    write_register(mexp_pkg::CFG_GENERATOR, 64'($urandom_range(0, 50)));
    run_random_phase(20);
    wait_idle();

    write_register(mexp_pkg::CFG_MODULUS, '1);
    write_register(mexp_pkg::CFG_GENERATOR, '1);
    run_random_phase(20);
    wait_idle();

    write_register(mexp_pkg::CFG_MODULUS, 64'd1);
    write_register(mexp_pkg::CFG_GENERATOR, {$urandom, $urandom});
    run_random_phase(10);
    wait_idle();

    // Back-to-back items and results, no idling on either side.
    write_register(mexp_pkg::CFG_MODULUS, {32'd0, $urandom} | 64'd1);
    write_register(mexp_pkg::CFG_GENERATOR, 64'd2);
    quiet = 1'b1;
    run_random_phase(20);
    wait_idle();
    quiet = 1'b0;

    write_register(mexp_pkg::CFG_MODULUS, {$urandom, $urandom} | (64'd1 << 63));
    write_register(mexp_pkg::CFG_GENERATOR, {$urandom, $urandom});
    run_random_phase(22);
    wait_idle();

    // Anything arriving now has no item behind it.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending_powers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation_key_agreement_unit.sv
verif/testbench.sv
